@@ rtl/core/pra_pkg.sv @@
// shared types, constants and tables for the point rotation block
`timescale 1ns / 1ps

package pra_pkg;

  // parameter defaults
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // cordic table length and internal word widths
  localparam int MAX_STAGES = 24;
  localparam int WORD_W     = 64;
  localparam int CW_W       = 34;
  localparam int BIT_CNT_W  = 5;
  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

  // register indexes
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_AXIS_X   = 3'd3;
  localparam logic [2:0] CFG_AXIS_Y   = 3'd4;
  localparam logic [2:0] CFG_AXIS_Z   = 3'd5;
  localparam logic [2:0] CFG_ANGLE    = 3'd6;

  // quadrant codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_RUN
  } setup_st_t;

  // one cordic cell's hand-off
  typedef struct packed {
    logic signed [CW_W-1:0] x;
    logic signed [CW_W-1:0] y;
    logic signed [CW_W-1:0] z;
    logic                   zq;
    logic [1:0]             quad;
  } cordic_t;

  // one point on its way through the pipeline
  typedef struct packed {
    logic                    vld;
    logic [2:0][WORD_W-1:0]  p;
    logic [2:0][WORD_W-1:0]  v;
    logic [WORD_W-1:0]       dot;
    logic [2:0][WORD_W-1:0]  par;
    logic [2:0][WORD_W-1:0]  q;
    logic [2:0][WORD_W-1:0]  w;
    logic [2:0][WORD_W-1:0]  t;
    logic                    qnz;
  } item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] tab [MAX_STAGES];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
            32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304,
            32'd652, 32'd326, 32'd163, 32'd81};
    return tab[idx];
  endfunction

endpackage

@@ rtl/core/pra_cordic_cell.sv @@
// one rotation cell of the sine and cosine chain
`timescale 1ns / 1ps

module pra_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  pra_pkg::cordic_t cin,
  output pra_pkg::cordic_t cout
);
  import pra_pkg::*;

  localparam logic signed [CW_W-1:0] ATAN = {2'b00, atan_turn(IDX)};

  cordic_t cout_r, cout_nxt;

  always_comb begin
    cout_nxt = cin;
    if (!cin.z[CW_W-1]) begin
      cout_nxt.x = cin.x - (cin.y >>> IDX);
      cout_nxt.y = cin.y + (cin.x >>> IDX);
      cout_nxt.z = cin.z - ATAN;
    end else begin
      cout_nxt.x = cin.x + (cin.y >>> IDX);
      cout_nxt.y = cin.y - (cin.x >>> IDX);
      cout_nxt.z = cin.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    cout_r <= cout_nxt;
  end

  assign cout = cout_r;

endmodule

@@ rtl/core/pra_mul.sv @@
// two-stage 32 by 64 bit multiply, product kept modulo 2^64
`timescale 1ns / 1ps

module pra_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic [63:0]        b,
  output logic [63:0]        p
);
  import pra_pkg::*;

  logic signed [WORD_W-1:0] a64, blo64;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [31:0]       hi_r, hi_nxt;
  logic [WORD_W-1:0] p_r;

  assign a64   = WORD_W'(a);
  assign blo64 = {32'b0, b[31:0]};

  always_comb begin
    lo_nxt = a64 * blo64;
    hi_nxt = a[31:0] * b[63:32];
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    p_r  <= lo_r + {hi_r, 32'b0};
  end

  assign p = p_r;

endmodule

@@ rtl/core/point_rotate_about_axis.sv @@
// top level: rotation of a point stream about a configured axis and origin
`timescale 1ns / 1ps

// channel   ports                               beat taken when
// ------    --------------------------------    -----------------------
// input     start, busy, in_point_x/y/z          start high, busy low
// result    out_strobe, out_rotated_x/y/z,       out_strobe high (1 cycle)
//           out_on_axis
// config    cfg_we, cfg_index, cfg_data          cfg_we high
//
// a point is taken every cycle while busy is low; each result passes
// through the point pipeline registers and the output register; after
// reset and after every config write a setup pass runs with busy high:
//   load, axis normalize (up to 29 single-bit shifts plus one), 3 squares,
//   32 square root steps and UB+1 divide steps; a zero axis ends in normalize
// the cordic cells run the whole time on the stored angle and are sampled
// when the divide ends; the receiver cannot stall, results never wait

module point_rotate_about_axis #(
  parameter int COORD_WIDTH   = pra_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS     = pra_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = pra_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  output logic                          out_strobe,
  output logic signed [COORD_WIDTH-1:0] out_rotated_x,
  output logic signed [COORD_WIDTH-1:0] out_rotated_y,
  output logic signed [COORD_WIDTH-1:0] out_rotated_z,
  output logic                          out_on_axis,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);
  import pra_pkg::*;

  // unit vector format, normalize word width, cordic cells in use
  localparam int UB  = ((61 - COORD_WIDTH) < 30) ? (61 - COORD_WIDTH) : 30;
  localparam int NW  = (COORD_WIDTH > 31) ? COORD_WIDTH : 31;
  localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = 13;
  // rotation does not depend on the binary point
  localparam int FB_UNUSED = FRAC_BITS - FRAC_BITS;
  localparam logic signed [CW_W-1:0] GAIN_X = CW_W'(GAIN_Q32 >> (32 - UB + FB_UNUSED));
  localparam logic signed [31:0] ONE_U = 32'(64'd1 << UB);

  function automatic logic [WORD_W-1:0] sx(input logic [COORD_WIDTH-1:0] a);
    return {{(WORD_W-COORD_WIDTH){a[COORD_WIDTH-1]}}, a};
  endfunction

  function automatic logic [WORD_W-1:0] asr_u(input logic [WORD_W-1:0] a);
    return $signed(a) >>> UB;
  endfunction

  // configuration registers
  logic [2:0][COORD_WIDTH-1:0] org_r, axs_r;
  logic [15:0]                 ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0;
      axs_r <= {COORD_WIDTH'(65536), {(2*COORD_WIDTH){1'b0}}};
      ang_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: org_r[0] <= cfg_data;
        CFG_ORIGIN_Y: org_r[1] <= cfg_data;
        CFG_ORIGIN_Z: org_r[2] <= cfg_data;
        CFG_AXIS_X:   axs_r[0] <= cfg_data;
        CFG_AXIS_Y:   axs_r[1] <= cfg_data;
        CFG_AXIS_Z:   axs_r[2] <= cfg_data;
        CFG_ANGLE:    ang_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sine and cosine: a row of cordic cells fed from the angle register
  cordic_t chain [NST+1];

  assign chain[0].x    = GAIN_X;
  assign chain[0].y    = '0;
  assign chain[0].z    = {4'b0, ang_r[13:0], 16'b0};
  assign chain[0].zq   = (ang_r[13:0] == 14'd0);
  assign chain[0].quad = ang_r[15:14];

  for (genvar g = 0; g < NST; g++) begin : g_cordic
    pra_cordic_cell #(.IDX(g)) u_cell (
      .clk  (clk),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  // setup sequencer: unit axis, then latch sine and cosine
  setup_st_t st_r, st_nxt;
  logic [2:0][NW-1:0]     n_r, n_nxt;
  logic [2:0]             sg_r, sg_nxt;
  logic [NW-1:0]          m_r, m_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic [WORD_W-1:0]      s2_r, s2_nxt;
  logic [WORD_W-1:0]      sqx_r, sqx_nxt, sqr_r, sqr_nxt, sqb_r, sqb_nxt;
  logic [2:0][WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0]      dsh_r, dsh_nxt;
  logic [2:0][31:0]       qt_r, qt_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;
  logic [2:0][31:0]       u_r, u_nxt;
  logic signed [31:0]     c_r, c_nxt, s_r, s_nxt;
  logic                   zax_r, zax_nxt;

  logic [2:0][NW-1:0] mg;
  logic [WORD_W-1:0]  rb, nsq;
  logic signed [31:0] cx, cy;
  logic               ge;

  always_comb begin
    st_nxt  = st_r;
    n_nxt   = n_r;
    sg_nxt  = sg_r;
    m_nxt   = m_r;
    cnt_nxt = cnt_r;
    s2_nxt  = s2_r;
    sqx_nxt = sqx_r;
    sqr_nxt = sqr_r;
    sqb_nxt = sqb_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    qt_nxt  = qt_r;
    bit_nxt = bit_r;
    u_nxt   = u_r;
    c_nxt   = c_r;
    s_nxt   = s_r;
    zax_nxt = zax_r;
    ge      = 1'b0;
    rb      = sqr_r + sqb_r;
    nsq     = WORD_W'(n_r[cnt_r][29:0]) * WORD_W'(n_r[cnt_r][29:0]);
    for (int i = 0; i < 3; i++) begin
      mg[i] = axs_r[i][COORD_WIDTH-1] ? NW'(-sx(axs_r[i])) : NW'(axs_r[i]);
    end
    // sampled trig with the exact quarter-turn case
    cx = chain[NST].zq ? ONE_U : 32'(chain[NST].x);
    cy = chain[NST].zq ? 32'sd0 : 32'(chain[NST].y);

    unique case (st_r)
      ST_LOAD: begin
        n_nxt  = mg;
        for (int i = 0; i < 3; i++) sg_nxt[i] = axs_r[i][COORD_WIDTH-1];
        m_nxt  = mg[0];
        if (mg[1] > m_nxt) m_nxt = mg[1];
        if (mg[2] > m_nxt) m_nxt = mg[2];
        s2_nxt  = '0;
        cnt_nxt = '0;
        st_nxt  = ST_NORM;
      end
      ST_NORM: begin
        priority if (m_r == '0) begin
          zax_nxt = 1'b1;
          st_nxt  = ST_RUN;
        end else if (|m_r[NW-1:30]) begin
          // truncating shifts one bit at a time
          for (int i = 0; i < 3; i++) n_nxt[i] = n_r[i] >> 1;
          m_nxt = m_r >> 1;
        end else if (m_r[NW-1:29] == '0) begin
          for (int i = 0; i < 3; i++) n_nxt[i] = n_r[i] << 1;
          m_nxt = m_r << 1;
        end else begin
          zax_nxt = 1'b0;
          st_nxt  = ST_SQ;
        end
      end
      ST_SQ: begin
        s2_nxt  = s2_r + nsq;
        if (cnt_r == 2'd2) begin
          sqx_nxt = s2_r + nsq;
          sqr_nxt = '0;
          sqb_nxt = 64'd1 << 62;
          st_nxt  = ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_SQRT: begin
        if (sqx_r >= rb) begin
          sqx_nxt = sqx_r - rb;
          sqr_nxt = (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_nxt = sqr_r >> 1;
        end
        sqb_nxt = sqb_r >> 2;
        if (sqb_r == 64'd1) begin
          dsh_nxt = sqr_nxt << UB;
          for (int i = 0; i < 3; i++) begin
            rem_nxt[i] = WORD_W'(n_r[i][29:0]) << UB;
          end
          qt_nxt  = '0;
          bit_nxt = BIT_CNT_W'(UB);
          st_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle in each of the three lanes
        for (int i = 0; i < 3; i++) begin
          ge = (rem_r[i] >= dsh_r);
          if (ge) rem_nxt[i] = rem_r[i] - dsh_r;
          qt_nxt[i] = {qt_r[i][30:0], ge};
        end
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          for (int i = 0; i < 3; i++) begin
            u_nxt[i] = sg_r[i] ? -qt_nxt[i] : qt_nxt[i];
          end
          unique case (chain[NST].quad)
            QUAD_0: begin c_nxt = cx;  s_nxt = cy;  end
            QUAD_1: begin c_nxt = -cy; s_nxt = cx;  end
            QUAD_2: begin c_nxt = -cx; s_nxt = -cy; end
            QUAD_3: begin c_nxt = cy;  s_nxt = -cx; end
            default: ;
          endcase
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: ;
      default: st_nxt = ST_LOAD;
    endcase

    if (cfg_we) st_nxt = ST_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      zax_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      zax_r <= zax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    sg_r  <= sg_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
    s2_r  <= s2_nxt;
    sqx_r <= sqx_nxt;
    sqr_r <= sqr_nxt;
    sqb_r <= sqb_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    qt_r  <= qt_nxt;
    bit_r <= bit_nxt;
    u_r   <= u_nxt;
    c_r   <= c_nxt;
    s_r   <= s_nxt;
  end

  assign busy = (st_r != ST_RUN);

  // point pipeline
  logic  accept;
  item_t rec_r [LAT];
  item_t rec_nxt [LAT];
  logic [2:0][WORD_W-1:0] ma, mb, md_c, md_s;
  logic [5:0][WORD_W-1:0] mc;

  assign accept = start && !busy;

  // u . v terms, aligned with stage 2
  for (genvar g = 0; g < 3; g++) begin : g_mul_a
    pra_mul u_mul (.clk(clk), .a(u_r[g]), .b(rec_r[0].v[g]), .p(ma[g]));
  end
  // along-axis part, aligned with stage 5
  for (genvar g = 0; g < 3; g++) begin : g_mul_b
    pra_mul u_mul (.clk(clk), .a(u_r[g]), .b(rec_r[3].dot), .p(mb[g]));
  end
  // cross product terms, aligned with stage 8
  pra_mul u_mc0 (.clk(clk), .a(u_r[1]), .b(rec_r[6].q[2]), .p(mc[0]));
  pra_mul u_mc1 (.clk(clk), .a(u_r[2]), .b(rec_r[6].q[1]), .p(mc[1]));
  pra_mul u_mc2 (.clk(clk), .a(u_r[2]), .b(rec_r[6].q[0]), .p(mc[2]));
  pra_mul u_mc3 (.clk(clk), .a(u_r[0]), .b(rec_r[6].q[2]), .p(mc[3]));
  pra_mul u_mc4 (.clk(clk), .a(u_r[0]), .b(rec_r[6].q[1]), .p(mc[4]));
  pra_mul u_mc5 (.clk(clk), .a(u_r[1]), .b(rec_r[6].q[0]), .p(mc[5]));
  // cos and sin terms, aligned with stage 11
  for (genvar g = 0; g < 3; g++) begin : g_mul_d
    pra_mul u_mc (.clk(clk), .a(c_r), .b(rec_r[9].q[g]), .p(md_c[g]));
    pra_mul u_ms (.clk(clk), .a(s_r), .b(rec_r[9].w[g]), .p(md_s[g]));
  end

  always_comb begin
    rec_nxt[0]       = rec_r[0];
    rec_nxt[0].vld   = accept;
    rec_nxt[0].p[0]  = sx(in_point_x);
    rec_nxt[0].p[1]  = sx(in_point_y);
    rec_nxt[0].p[2]  = sx(in_point_z);
    for (int i = 0; i < 3; i++) begin
      rec_nxt[0].v[i] = rec_nxt[0].p[i] - sx(org_r[i]);
    end
    for (int k = 1; k < LAT; k++) rec_nxt[k] = rec_r[k-1];

    rec_nxt[3].dot = asr_u(ma[0] + ma[1] + ma[2]);

    for (int i = 0; i < 3; i++) begin
      rec_nxt[6].par[i] = asr_u(mb[i]);
      rec_nxt[6].q[i]   = rec_r[5].v[i] - asr_u(mb[i]);
    end

    rec_nxt[9].w[0] = asr_u(mc[0] - mc[1]);
    rec_nxt[9].w[1] = asr_u(mc[2] - mc[3]);
    rec_nxt[9].w[2] = asr_u(mc[4] - mc[5]);
    rec_nxt[9].qnz  = |(rec_r[8].q[0] | rec_r[8].q[1] | rec_r[8].q[2]);

    for (int i = 0; i < 3; i++) begin
      rec_nxt[12].t[i] = asr_u(md_c[i] + md_s[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) rec_r[k] <= '0;
    end else begin
      for (int k = 0; k < LAT; k++) rec_r[k] <= rec_nxt[k];
    end
  end

  // output register
  logic                          strobe_r, on_axis_r, on_axis_nxt;
  logic [2:0][COORD_WIDTH-1:0]   res_r, res_nxt;

  always_comb begin
    on_axis_nxt = zax_r || !rec_r[LAT-1].qnz;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = on_axis_nxt ? rec_r[LAT-1].p[i][COORD_WIDTH-1:0]
                 : COORD_WIDTH'(sx(org_r[i]) + rec_r[LAT-1].par[i] + rec_r[LAT-1].t[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= rec_r[LAT-1].vld;
  end

  always_ff @(posedge clk) begin
    on_axis_r <= on_axis_nxt;
    res_r     <= res_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_on_axis   = on_axis_r;
  assign out_rotated_x = res_r[0];
  assign out_rotated_y = res_r[1];
  assign out_rotated_z = res_r[2];

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> rec_r[0].vld) else $error("accepted beat not in pipeline");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy) else $error("no setup pass after config write");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r[LAT-1].vld |=> out_strobe) else $error("result beat lost");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && zax_r |-> out_on_axis) else $error("zero axis not flagged");

endmodule
